// ===== rtl/core/rc4sc_pkg.sv =====
package rc4sc_pkg;

	// Default geometry of the permutation and of the key.
	localparam int STATE_SIZE_DEF    = 64;
	localparam int MAX_KEY_BYTES_DEF = 24;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_MID  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_LEN  = 2'd3;

	localparam int KEY_LEN_W = 5;

	// Sequencer states: key schedule and keystream generation.
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_INIT  = 10'b00_0000_0010,
		ST_KA    = 10'b00_0000_0100,
		ST_KB    = 10'b00_0000_1000,
		ST_KC    = 10'b00_0001_0000,
		ST_KD    = 10'b00_0010_0000,
		ST_START = 10'b00_0100_0000,
		ST_PJ    = 10'b00_1000_0000,
		ST_PT    = 10'b01_0000_0000,
		ST_PW    = 10'b10_0000_0000
	} rc4sc_state_t;

endpackage

// ===== rtl/core/rc4_stream_cipher.sv =====
// RC4-style stream cipher over a permutation of STATE_SIZE entries held in one
// synchronous memory (one read and one write per cycle, registered read data).
// Each input beat returns one output beat, data XOR keystream. In steady state the
// read of S[i], the read of S[j] and the read of the keystream entry follow each
// other through the single read port, with the swap writes slotted in alongside.
// The first beat after reset, or a beat with rekey set in tuser, first runs the
// key schedule: ST_INIT loads the identity, ST_KA to ST_KD do the keyed swaps
// and ST_START restarts the stream. Key registers must be written through the
// cfg port only while idle; the block itself does not enforce this. They take
// effect at the next rekey.
module rc4_stream_cipher #(
	parameter int STATE_SIZE    = rc4sc_pkg::STATE_SIZE_DEF,
	parameter int MAX_KEY_BYTES = rc4sc_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [rc4sc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [rc4sc_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	input  logic                            s_axis_tuser,  // [0] rekey
	// Output stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata   // [7:0] out_byte
);

	import rc4sc_pkg::*;

	localparam int IW = $clog2(STATE_SIZE);
	localparam logic [IW:0]   NVAL = (IW+1)'(STATE_SIZE);
	localparam logic [IW-1:0] LAST = IW'(STATE_SIZE - 1);
	localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

	// Reduces a key byte modulo the state size by restoring subtraction.
	function automatic logic [IW-1:0] mod_byte(input logic [7:0] v);
		logic [15:0] r;
		r = 16'(v);
		for (int s = 7; s >= 0; s--) begin
			if (r >= (16'(STATE_SIZE) << s)) begin
				r = r - (16'(STATE_SIZE) << s);
			end
		end
		return r[IW-1:0];
	endfunction

	// Configuration registers.
	logic [CFG_DATA_W-1:0] key_low_q, key_mid_q, key_high_q;
	logic [KEY_LEN_W-1:0]  key_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_mid_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= KEY_LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_MID:  key_mid_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LEN:  key_len_q  <= cfg_data[KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective key length, clamped to the legal range.
	logic [KEY_LEN_W-1:0] len_eff;
	always_comb begin
		if (key_len_q == '0) begin
			len_eff = KEY_LEN_W'(1);
		end else if (key_len_q > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = key_len_q;
		end
	end

	// Sequencer and datapath registers.
	rc4sc_state_t state_q;
	logic          keyed_q;
	logic [IW-1:0] i_q, j_q;
	logic [IW-1:0] p_q, acc_q, sp_q, kred_q;
	logic [KEY_LEN_W-1:0] kidx_q;
	logic [IW-1:0] si_q;
	logic          fwd_q;
	logic          ks_fwd_q;
	logic [IW-1:0] ks_val_q;
	logic [7:0]    data_q;
	logic          out_valid_q;
	logic [7:0]    out_data_q;

	// Permutation memory ports.
	logic          mem_we, mem_re;
	logic [IW-1:0] mem_wa, mem_wd, mem_ra;
	logic [IW-1:0] rd_q;
	logic [IW-1:0] mem [STATE_SIZE];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// Handshake decode.
	logic out_load, accept, need_key;
	assign out_load      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) || ((state_q == ST_PW) && out_load);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign need_key      = s_axis_tuser || !keyed_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Key byte for the current schedule position.
	logic [3*CFG_DATA_W-1:0] key_all;
	logic [7:0]              key_byte;
	assign key_all  = {key_high_q, key_mid_q, key_low_q};
	assign key_byte = key_all[{kidx_q, 3'b000} +: 8];

	// Stream arithmetic, all modulo the state size.
	logic [IW-1:0] i_n, si, j_n, t_idx, ks, acc_n;
	logic [IW:0]   j_sum, t_sum;
	logic [IW+1:0] a_sum, a_red;
	always_comb begin
		i_n   = (i_q == LAST) ? '0 : i_q + 1'b1;
		si    = fwd_q ? si_q : rd_q;
		j_sum = (IW+1)'(j_q) + (IW+1)'(si);
		j_n   = (j_sum >= NVAL) ? IW'(j_sum - NVAL) : j_sum[IW-1:0];
		t_sum = (IW+1)'(si_q) + (IW+1)'(rd_q);
		t_idx = (t_sum >= NVAL) ? IW'(t_sum - NVAL) : t_sum[IW-1:0];
		ks    = ks_fwd_q ? ks_val_q : rd_q;
		a_sum = (IW+2)'(acc_q) + (IW+2)'(rd_q) + (IW+2)'(kred_q);
		a_red = (a_sum >= (IW+2)'(NVAL)) ? a_sum - (IW+2)'(NVAL) : a_sum;
		acc_n = (a_red >= (IW+2)'(NVAL)) ? IW'(a_red - (IW+2)'(NVAL)) : a_red[IW-1:0];
	end

	// Memory port control per state.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = p_q;
		mem_wd = p_q;
		mem_re = 1'b0;
		mem_ra = i_n;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_KA: begin
				mem_re = 1'b1;
				mem_ra = p_q;
			end
			ST_KB: begin
				mem_re = 1'b1;
				mem_ra = acc_n;
			end
			ST_KC: begin
				mem_we = 1'b1;
				mem_wd = rd_q;
			end
			ST_KD: begin
				mem_we = 1'b1;
				mem_wa = acc_q;
				mem_wd = sp_q;
			end
			ST_START: begin
				mem_re = 1'b1;
			end
			ST_PJ: begin
				mem_re = 1'b1;
				mem_ra = j_n;
			end
			ST_PT: begin
				mem_we = 1'b1;
				mem_wa = i_q;
				mem_wd = rd_q;
				mem_re = 1'b1;
				mem_ra = t_idx;
			end
			ST_PW: begin
				mem_we = 1'b1;
				mem_wa = j_q;
				mem_wd = si_q;
				mem_re = accept && !need_key;
			end
			default: begin
				mem_re = accept && !need_key;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keyed_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			p_q         <= '0;
			acc_q       <= '0;
			sp_q        <= '0;
			kred_q      <= '0;
			kidx_q      <= '0;
			si_q        <= '0;
			fwd_q       <= 1'b0;
			ks_fwd_q    <= 1'b0;
			ks_val_q    <= '0;
			data_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// A consumed beat empties the output unless a new one loads in the same cycle.
			if (m_axis_tready && !((state_q == ST_PW) && out_load)) begin
				out_valid_q <= 1'b0;
			end
			// A new beat either starts the key schedule or reads S[i+1].
			if (accept) begin
				data_q <= s_axis_tdata;
				if (need_key) begin
					state_q <= ST_INIT;
					p_q     <= '0;
				end else begin
					state_q <= ST_PJ;
					i_q     <= i_n;
					// The pending swap write of S[j] lands on the entry just read.
					fwd_q   <= (state_q == ST_PW) && (i_n == j_q);
				end
			end
			case (state_q)
				ST_INIT: begin
					if (p_q == LAST) begin
						state_q <= ST_KA;
						p_q     <= '0;
						acc_q   <= '0;
						kidx_q  <= '0;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_KA: begin
					kred_q  <= mod_byte(key_byte);
					state_q <= ST_KB;
				end
				ST_KB: begin
					acc_q   <= acc_n;
					sp_q    <= rd_q;
					state_q <= ST_KC;
				end
				ST_KC: begin
					state_q <= ST_KD;
				end
				ST_KD: begin
					kidx_q <= (kidx_q + 1'b1 == len_eff) ? '0 : kidx_q + 1'b1;
					if (p_q == LAST) begin
						state_q <= ST_START;
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= ST_KA;
					end
				end
				ST_START: begin
					i_q     <= i_n;
					fwd_q   <= 1'b0;
					state_q <= ST_PJ;
				end
				ST_PJ: begin
					si_q    <= si;
					j_q     <= j_n;
					state_q <= ST_PT;
				end
				ST_PT: begin
					// S[i] is written this cycle and S[j] next, so forward both.
					ks_fwd_q <= (t_idx == i_q) || (t_idx == j_q);
					ks_val_q <= (t_idx == i_q) ? rd_q : si_q;
					state_q  <= ST_PW;
				end
				ST_PW: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_data_q  <= data_q ^ 8'(ks);
						if (!accept) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
